// ===== hw/rtl/pdic_pkg.sv =====
// Shared types and constants for the PID controller with deadband and integral clamp.
`timescale 1ns / 1ps

package pdic_pkg;

    // Field widths
    localparam int VALUE_W = 24;   // target and measured value
    localparam int GAIN_W  = 16;   // Q8.8 gains
    localparam int DBAND_W = 23;   // deadband magnitude
    localparam int LIMIT_W = 31;   // integral clamp magnitude
    localparam int ERR_W   = 25;   // error, never saturated
    localparam int DIFF_W  = 26;   // error minus previous error
    localparam int SUM_W   = 32;   // clamped integral
    localparam int DRIVE_W = 32;   // drive output
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Product and accumulator widths
    localparam int PROD_P_W = GAIN_W + ERR_W;
    localparam int PROD_I_W = GAIN_W + SUM_W;
    localparam int PROD_D_W = GAIN_W + DIFF_W;
    localparam int ACC_W    = PROD_I_W + 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TARGET         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd5;

    // Reset values
    localparam logic [DBAND_W-1:0] DEAD_BAND_RST      = 23'd128;
    localparam logic [LIMIT_W-1:0] INTEGRAL_LIMIT_RST = 31'd2560000;

    // Output saturation bounds
    localparam logic [DRIVE_W-1:0] DRIVE_MAX = 32'h7FFF_FFFF;
    localparam logic [DRIVE_W-1:0] DRIVE_MIN = 32'h8000_0000;

    // Terms handed from the error stage to the gain stage
    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [SUM_W-1:0]  sum;
        logic signed [DIFF_W-1:0] diff;
    } pdic_terms_t;

endpackage

// ===== hw/rtl/pdic_error_stage.sv =====
// Error, deadband, clamped integral and derivative term; holds the controller state.
`timescale 1ns / 1ps

module pdic_error_stage
    import pdic_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      take,
    input  logic signed [VALUE_W-1:0] measured_value,
    input  logic signed [VALUE_W-1:0] target,
    input  logic        [DBAND_W-1:0] dead_band,
    input  logic        [LIMIT_W-1:0] integral_limit,
    output pdic_terms_t               terms
);

    // terms_reg.sum is the integral, terms_reg.err the previous error
    pdic_terms_t terms_reg;
    pdic_terms_t terms_next;

    logic signed [ERR_W-1:0]  err_raw;
    logic signed [ERR_W:0]    err_ext;
    logic signed [ERR_W:0]    db_pos;
    logic signed [ERR_W:0]    db_neg;
    logic                     in_band;
    logic signed [ERR_W-1:0]  err_z;
    logic signed [SUM_W:0]    sum_full;
    logic signed [SUM_W:0]    lim_pos;
    logic signed [SUM_W:0]    lim_neg;
    logic signed [SUM_W:0]    sum_ext;

    // Error and deadband
    assign err_raw = {target[VALUE_W-1], target} - {measured_value[VALUE_W-1], measured_value};
    assign err_ext = {err_raw[ERR_W-1], err_raw};
    assign db_pos  = {{(ERR_W+1-DBAND_W){1'b0}}, dead_band};
    assign db_neg  = -db_pos;
    assign in_band = (err_ext < db_pos) && (err_ext > db_neg);
    assign err_z   = in_band ? '0 : err_raw;

    // Integral at full width, then clamp
    assign sum_full = {terms_reg.sum[SUM_W-1], terms_reg.sum}
                    + {{(SUM_W+1-ERR_W){err_z[ERR_W-1]}}, err_z};
    assign lim_pos  = {{(SUM_W+1-LIMIT_W){1'b0}}, integral_limit};
    assign lim_neg  = -lim_pos;
    assign sum_ext  = {terms_reg.sum[SUM_W-1], terms_reg.sum};

    always_comb
    begin
        terms_next.err  = err_z;
        terms_next.diff = {err_z[ERR_W-1], err_z} - {terms_reg.err[ERR_W-1], terms_reg.err};
        priority if (sum_full > lim_pos)
        begin
            terms_next.sum = lim_pos[SUM_W-1:0];
        end
        else if (sum_full < lim_neg)
        begin
            terms_next.sum = lim_neg[SUM_W-1:0];
        end
        else
        begin
            terms_next.sum = sum_full[SUM_W-1:0];
        end
    end

    // State update on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            terms_reg <= '0;
        end
        else if (take)
        begin
            terms_reg <= terms_next;
        end
    end

    assign terms = terms_reg;

    // Integral stays within the limit it was clamped against
    a_sum_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (sum_ext <= $past(lim_pos)) && (sum_ext >= $past(lim_neg)))
        else $error("integral outside clamp");

    // Stored error is zero or outside the deadband it was tested against
    a_err_band: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> (terms_reg.err == '0)
              || ($signed({terms_reg.err[ERR_W-1], terms_reg.err}) >= $past(db_pos))
              || ($signed({terms_reg.err[ERR_W-1], terms_reg.err}) <= $past(db_neg)))
        else $error("nonzero error inside deadband");

endmodule

// ===== hw/rtl/pid_deadband_integral_clamp.sv =====
// Top level of the PID controller with error deadband and integral clamp.
//
// Usage:
//   Input channel (in_valid/in_ready, measured_value): one plant sample per item.
//   Output channel (out_valid/out_ready, drive_value): one drive value per item,
//   in the order the samples were taken.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): writes target,
//   gains, deadband and integral limit; always ready, unknown indexes ignored.
//   Write config only while no item is in flight.
// Timing:
//   Three-stage pipeline: error/integral, gain products, sum/shift/saturate.
//   A sample passes the error, product and drive registers before out_valid rises;
//   one item per cycle sustained while out_ready holds high. The integral loop (subtract,
//   deadband test, add, clamp) closes within the error stage, which sets the item rate.
// Reset:
//   Clears the integral, the previous error, all pipeline valids and loads the
//   register reset values (deadband 128, integral limit 2560000, others zero).
// Stall:
//   A stalled out_ready backs the pipeline up stage by stage; in_ready drops
//   only once every stage holds an item.
`timescale 1ns / 1ps

module pid_deadband_integral_clamp
    import pdic_pkg::*;
#(
    parameter int FRAC_BITS = 8
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [VALUE_W-1:0]    measured_value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DRIVE_W-1:0]    drive_value,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic        [CFG_IDX_W-1:0]  cfg_index,
    input  logic        [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers
    logic signed [VALUE_W-1:0] target_reg;
    logic signed [GAIN_W-1:0]  gain_p_reg;
    logic signed [GAIN_W-1:0]  gain_i_reg;
    logic signed [GAIN_W-1:0]  gain_d_reg;
    logic        [DBAND_W-1:0] dead_band_reg;
    logic        [LIMIT_W-1:0] integral_limit_reg;

    // Pipeline control
    logic v1_reg, v2_reg, out_valid_reg;
    logic adv1, adv2, adv_out;
    logic take;

    // Pipeline payload
    pdic_terms_t                 terms;
    logic signed [PROD_P_W-1:0]  prod_p_reg;
    logic signed [PROD_I_W-1:0]  prod_i_reg;
    logic signed [PROD_D_W-1:0]  prod_d_reg;
    logic signed [PROD_P_W-1:0]  prod_p_next;
    logic signed [PROD_I_W-1:0]  prod_i_next;
    logic signed [PROD_D_W-1:0]  prod_d_next;
    logic signed [ACC_W-1:0]     acc;
    logic signed [ACC_W-1:0]     shifted;
    logic                        fits;
    logic        [DRIVE_W-1:0]   drive_reg;
    logic        [DRIVE_W-1:0]   drive_next;

    assign cfg_ready = 1'b1;

    // Config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg         <= '0;
            gain_p_reg         <= '0;
            gain_i_reg         <= '0;
            gain_d_reg         <= '0;
            dead_band_reg      <= DEAD_BAND_RST;
            integral_limit_reg <= INTEGRAL_LIMIT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TARGET:         target_reg         <= cfg_data[VALUE_W-1:0];
                REG_GAIN_P:         gain_p_reg         <= cfg_data[GAIN_W-1:0];
                REG_GAIN_I:         gain_i_reg         <= cfg_data[GAIN_W-1:0];
                REG_GAIN_D:         gain_d_reg         <= cfg_data[GAIN_W-1:0];
                REG_DEAD_BAND:      dead_band_reg      <= cfg_data[DBAND_W-1:0];
                REG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_data[LIMIT_W-1:0];
                default:            ;
            endcase
        end
    end

    // Stage advance: a stage moves when it is empty or the next one moves
    assign adv_out  = !out_valid_reg || out_ready;
    assign adv2     = !v2_reg || adv_out;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;
    assign take     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= in_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv_out)
            begin
                out_valid_reg <= v2_reg;
            end
        end
    end

    // Stage 1: error and integral
    pdic_error_stage u_error_stage (
        .clk            (clk),
        .rst_n          (rst_n),
        .take           (take),
        .measured_value (measured_value),
        .target         (target_reg),
        .dead_band      (dead_band_reg),
        .integral_limit (integral_limit_reg),
        .terms          (terms)
    );

    // Stage 2: gain products
    assign prod_p_next = gain_p_reg * terms.err;
    assign prod_i_next = gain_i_reg * terms.sum;
    assign prod_d_next = gain_d_reg * terms.diff;

    always_ff @(posedge clk)
    begin
        if (adv2 && v1_reg)
        begin
            prod_p_reg <= prod_p_next;
            prod_i_reg <= prod_i_next;
            prod_d_reg <= prod_d_next;
        end
    end

    // Stage 3: sum, floor shift, saturate to 32 bits
    assign acc = {{(ACC_W-PROD_P_W){prod_p_reg[PROD_P_W-1]}}, prod_p_reg}
               + {{(ACC_W-PROD_I_W){prod_i_reg[PROD_I_W-1]}}, prod_i_reg}
               + {{(ACC_W-PROD_D_W){prod_d_reg[PROD_D_W-1]}}, prod_d_reg};
    assign shifted = acc >>> FRAC_BITS;
    assign fits    = (&shifted[ACC_W-1:DRIVE_W-1]) || !(|shifted[ACC_W-1:DRIVE_W-1]);

    always_comb
    begin
        priority if (fits)
        begin
            drive_next = shifted[DRIVE_W-1:0];
        end
        else if (shifted[ACC_W-1])
        begin
            drive_next = DRIVE_MIN;
        end
        else
        begin
            drive_next = DRIVE_MAX;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_out && v2_reg)
        begin
            drive_reg <= drive_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign drive_value = drive_reg;

    // Input stalls only when every stage is full and the output is blocked
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v1_reg && v2_reg && out_valid_reg && !out_ready))
        else $error("input stalled with room in pipeline");

    // An item in the product stage reaches the output register when it moves
    a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && adv_out) |=> out_valid_reg)
        else $error("item lost between product stage and output");

endmodule

// ===== bench/pdic_drive_scoreboard.sv =====
// Scoreboard for the PID bench: drive-value predictor and queue of expected drive values.
`timescale 1ns / 1ps

package pdic_tb_pkg;

    import pdic_pkg::*;

    // Indexes past the last register; writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam int     FRAC_SHIFT = 8;
    localparam longint DRIVE_HI   = 64'sd2147483647;
    localparam longint DRIVE_LO   = -64'sd2147483648;

    class pdic_drive_scoreboard;

        // Register copy
        logic signed [VALUE_W-1:0] target;
        logic signed [GAIN_W-1:0]  gain_p;
        logic signed [GAIN_W-1:0]  gain_i;
        logic signed [GAIN_W-1:0]  gain_d;
        logic        [DBAND_W-1:0] dead_band;
        logic        [LIMIT_W-1:0] integral_limit;

        // Controller state
        logic signed [SUM_W-1:0]   error_sum;
        logic signed [ERR_W-1:0]   last_error;

        logic signed [DRIVE_W-1:0] drive_q[$];

        function new();
            target         = '0;
            gain_p         = '0;
            gain_i         = '0;
            gain_d         = '0;
            dead_band      = DEAD_BAND_RST;
            integral_limit = INTEGRAL_LIMIT_RST;
            error_sum      = '0;
            last_error     = '0;
        endfunction

        // Register write as seen on the config channel; upper data bits dropped
        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TARGET:         target         = data[VALUE_W-1:0];
                REG_GAIN_P:         gain_p         = data[GAIN_W-1:0];
                REG_GAIN_I:         gain_i         = data[GAIN_W-1:0];
                REG_GAIN_D:         gain_d         = data[GAIN_W-1:0];
                REG_DEAD_BAND:      dead_band      = data[DBAND_W-1:0];
                REG_INTEGRAL_LIMIT: integral_limit = data[LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        // One accepted sample: advance the controller and queue its drive value
        function void note_sample(input logic signed [VALUE_W-1:0] sample);
            longint err;
            longint sum;
            longint acc;
            longint drive;
            longint band;
            longint lim;
            band = longint'(dead_band);
            lim  = longint'(integral_limit);
            err  = longint'(target) - longint'(sample);
            if (err < band && err > -band)
                err = 0;

            // integral is formed at full width, then clamped
            sum = longint'(error_sum) + err;
            if (sum > lim)
                sum = lim;
            else if (sum < -lim)
                sum = -lim;

            acc = longint'(gain_p) * err + longint'(gain_i) * sum
                + longint'(gain_d) * (err - longint'(last_error));
            drive = acc >>> FRAC_SHIFT;     // floor
            if (drive > DRIVE_HI)
                drive = DRIVE_HI;
            else if (drive < DRIVE_LO)
                drive = DRIVE_LO;

            error_sum  = sum[SUM_W-1:0];
            last_error = err[ERR_W-1:0];
            drive_q.push_back(drive[DRIVE_W-1:0]);
        endfunction

        // Compare one output item with the oldest expectation
        function bit check_drive(input logic signed [DRIVE_W-1:0] got,
                                 output logic signed [DRIVE_W-1:0] want,
                                 output bit had_want);
            want     = '0;
            had_want = (drive_q.size() != 0);
            if (!had_want)
                return 1'b0;
            want = drive_q.pop_front();
            return (got === want);
        endfunction

        function int pending();
            return drive_q.size();
        endfunction

    endclass

endpackage

// ===== bench/pid_deadband_integral_clamp_tb.sv =====
// Testbench for the PID controller: directed corners, then random configs and samples.
`timescale 1ns / 1ps

module pid_deadband_integral_clamp_tb;

    import pdic_pkg::*;
    import pdic_tb_pkg::*;

    localparam int SEGMENTS      = 12;
    localparam int SEG_ITEMS     = 90;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_PRINTS    = 40;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic signed [VALUE_W-1:0]    measured_value;
    logic                         out_valid;
    logic                         out_ready;
    logic signed [DRIVE_W-1:0]    drive_value;
    logic                         cfg_valid;
    logic                         cfg_ready;
    logic        [CFG_IDX_W-1:0]  cfg_index;
    logic        [CFG_DATA_W-1:0] cfg_data;

    pdic_drive_scoreboard sb = new();

    int  mismatches = 0;
    bit  gaps_on    = 1'b0;
    bit  stalls_on  = 1'b0;
    int  hold_len   = 0;

    logic signed [DRIVE_W-1:0] want_drive;
    bit                        had_want;

    pid_deadband_integral_clamp i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .measured_value (measured_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .drive_value    (drive_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop
    initial
    begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Monitor: check output items first, then note accepted samples and writes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (!sb.check_drive(drive_value, want_drive, had_want))
                begin
                    if (!had_want)
                        report_mismatch($sformatf("unexpected drive_value %0d", drive_value));
                    else
                        report_mismatch($sformatf("drive_value got %0d expected %0d",
                                                  drive_value, want_drive));
                end
            end
            if (in_valid && in_ready)
                sb.note_sample(measured_value);
            if (cfg_valid && cfg_ready)
                sb.write_reg(cfg_index, cfg_data);
        end
    end

    // Receiver: random stall bursts, or a long hold-off when asked
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                out_ready = 1'b0;
                repeat (hold_len - 1) @(negedge clk);
                hold_len = 0;
            end
            else if (stalls_on && $urandom_range(0, 5) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(0, 8)) @(negedge clk);
            end
            else
                out_ready = 1'b1;
        end
    end

    // Offer one sample and hold it until taken; valid stays high on return
    task automatic send_sample(input logic [VALUE_W-1:0] sample);
        @(negedge clk);
        in_valid       = 1'b1;
        measured_value = sample;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic pause_input(input int cycles);
        @(negedge clk);
        in_valid       = 1'b0;
        measured_value = VALUE_W'($urandom);
        repeat (cycles - 1) @(negedge clk);
    endtask

    // Stop offering samples and let every expected item come out
    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic end_writes();
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2, 3:    return GAIN_W'($urandom_range(0, 2048) - 1024);
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    // Samples cluster around the target and the deadband edges
    function automatic logic [VALUE_W-1:0] pick_sample();
        logic [VALUE_W-1:0] band_off;
        band_off = VALUE_W'(sb.dead_band) + VALUE_W'($urandom_range(0, 4)) - VALUE_W'(2);
        case ($urandom_range(0, 9))
            0, 1, 2: return VALUE_W'($urandom);
            3, 4, 5: return $urandom_range(0, 1) ? sb.target - band_off : sb.target + band_off;
            6, 7:    return sb.target + VALUE_W'($urandom_range(0, 8192)) - VALUE_W'(4096);
            8:       return $urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF;
            default: return sb.target;
        endcase
    endfunction

    // New random setting of every register; junk in the unused data bits
    task automatic load_random_config();
        logic [CFG_DATA_W-1:0] word;
        wait_drained();

        word = $urandom;
        case ($urandom_range(0, 5))
            0:       word[VALUE_W-1:0] = 24'h800000;
            1:       word[VALUE_W-1:0] = 24'h7FFFFF;
            default: ;
        endcase
        write_reg(REG_TARGET, word);

        word = $urandom;
        word[GAIN_W-1:0] = pick_gain();
        write_reg(REG_GAIN_P, word);
        word = $urandom;
        word[GAIN_W-1:0] = pick_gain();
        write_reg(REG_GAIN_I, word);
        word = $urandom;
        word[GAIN_W-1:0] = pick_gain();
        write_reg(REG_GAIN_D, word);

        word = $urandom;
        case ($urandom_range(0, 9))
            0:       word[DBAND_W-1:0] = '0;
            1:       word[DBAND_W-1:0] = '1;
            2:       ;
            default: word[DBAND_W-1:0] = DBAND_W'($urandom_range(0, 1024));
        endcase
        write_reg(REG_DEAD_BAND, word);

        word = $urandom;
        case ($urandom_range(0, 7))
            0:       word[LIMIT_W-1:0] = '0;
            1:       word[LIMIT_W-1:0] = '1;
            2, 3:    ;
            default: word[LIMIT_W-1:0] = LIMIT_W'($urandom_range(0, 1 << 22));
        endcase
        write_reg(REG_INTEGRAL_LIMIT, word);

        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
        end_writes();
    endtask

    // Main sequence
    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        measured_value = '0;
        cfg_valid      = 1'b0;
        cfg_index      = REG_TARGET;
        cfg_data       = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        stalls_on = 1'b1;

        // Reset settings: zero gains, integral still accumulates and clamps
        send_sample(24'd0);
        send_sample(24'd127);
        send_sample(-24'sd128);
        send_sample(24'h7FFFFF);

        // Deadband edges: exactly at the band is kept, just inside is zeroed
        wait_drained();
        write_reg(REG_TARGET, 32'd1000);
        write_reg(REG_GAIN_P, 32'd256);
        write_reg(REG_GAIN_I, 32'd16);
        write_reg(REG_GAIN_D, 32'hFFFF_FF80);
        write_reg(REG_DEAD_BAND, 32'd50);
        write_reg(REG_INTEGRAL_LIMIT, 32'd100000);
        end_writes();
        send_sample(24'd950);
        send_sample(24'd1050);
        send_sample(24'd951);
        send_sample(24'd1049);
        send_sample(24'd0);
        send_sample(24'd2000);

        // Zero deadband zeroes nothing
        wait_drained();
        write_reg(REG_DEAD_BAND, 32'd0);
        end_writes();
        send_sample(24'd1000);
        send_sample(24'd999);
        send_sample(24'd1001);

        // Full error range, widest deadband and limit, positive saturation
        wait_drained();
        write_reg(REG_TARGET, 32'h007F_FFFF);
        write_reg(REG_GAIN_P, 32'h0000_7FFF);
        write_reg(REG_GAIN_I, 32'h0000_7FFF);
        write_reg(REG_GAIN_D, 32'h0000_7FFF);
        write_reg(REG_DEAD_BAND, 32'h007F_FFFF);
        write_reg(REG_INTEGRAL_LIMIT, 32'h7FFF_FFFF);
        end_writes();
        send_sample(24'h800000);
        send_sample(24'h800000);
        send_sample(24'd0);
        send_sample(24'd1);

        // Most negative error, negative saturation
        wait_drained();
        write_reg(REG_TARGET, 32'h0080_0000);
        end_writes();
        send_sample(24'h7FFFFF);
        send_sample(24'h7FFFFF);

        // Lowered limit clamps the stored integral on the next sample
        wait_drained();
        write_reg(REG_INTEGRAL_LIMIT, 32'd1000);
        end_writes();
        send_sample(24'h800000);

        wait_drained();
        write_reg(REG_INTEGRAL_LIMIT, 32'd0);
        write_reg(REG_GAIN_P, 32'h0000_8000);
        end_writes();
        send_sample(24'h7FFFFF);

        // Writes past the last register change nothing
        wait_drained();
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_SPARE_HI, $urandom);
        end_writes();
        send_sample(24'h7FFFFF);
        send_sample(24'h000123);

        // Random segments; the last two run with no idling on either side
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            load_random_config();
            gaps_on   = (seg < SEGMENTS - 2);
            stalls_on = (seg < SEGMENTS - 2);
            if (seg == 2)
            begin
                // long receiver hold-off while samples keep coming
                hold_len = 60;
                repeat (16) send_sample(pick_sample());
            end
            for (int n = 0; n < SEG_ITEMS; n++)
            begin
                if (seg == 5 && n == SEG_ITEMS / 2)
                    wait_drained();
                if (gaps_on && $urandom_range(0, 4) == 0)
                    pause_input($urandom_range(1, 9));
                send_sample(pick_sample());
            end
        end

        wait_drained();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/pdic_pkg.sv
hw/rtl/pdic_error_stage.sv
hw/rtl/pid_deadband_integral_clamp.sv
bench/pdic_drive_scoreboard.sv
bench/pid_deadband_integral_clamp_tb.sv
